>>> rtl/aood_pkg.sv
package aood_pkg;

    // Default number of track blocks
    localparam int BLOCKS_DEF = 8;

    // Field widths
    localparam int BLK_W  = 3;
    localparam int CUR_W  = 16;
    localparam int TIME_W = 32;

    // EMA window limit on dt, in ms
    localparam logic [TIME_W-1:0] DT_LIMIT_MS = 32'd5000;
    localparam int DT_W = 13;

    // Shared divider geometry
    localparam int DIV_DVD_W = 30;
    localparam int DIV_DVS_W = 17;
    localparam int DIV_BITS  = 2;
    localparam int DIV_STEPS = DIV_DVD_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_LIMIT = 3'd0,
        CFG_HARD_LIMIT  = 3'd1,
        CFG_HOLD_TIME   = 3'd2,
        CFG_EMA_TAU     = 3'd3,
        CFG_FACTOR_NUM  = 3'd4,
        CFG_FACTOR_DEN  = 3'd5,
        CFG_MIN_JUMP    = 3'd6,
        CFG_MIN_BASE    = 3'd7
    } t_cfg_idx;

    // Register reset values
    localparam logic [15:0] RST_SHORT_LIMIT = 16'd2500;
    localparam logic [15:0] RST_HARD_LIMIT  = 16'd1500;
    localparam logic [15:0] RST_HOLD_TIME   = 16'd500;
    localparam logic [15:0] RST_EMA_TAU     = 16'd2000;
    localparam logic [7:0]  RST_FACTOR_NUM  = 8'd3;
    localparam logic [7:0]  RST_FACTOR_DEN  = 8'd2;
    localparam logic [15:0] RST_MIN_JUMP    = 16'd200;
    localparam logic [15:0] RST_MIN_BASE    = 16'd50;

    typedef struct packed {
        logic [BLK_W-1:0]  block_index;
        logic [CUR_W-1:0]  current_ma;
        logic              occupied;
        logic              power_stable;
        logic [TIME_W-1:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [BLK_W-1:0] block_out;
        logic             trip;
        logic             hard_cause;
        logic [CUR_W-1:0] baseline_out;
    } t_out;

    // Controller state
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_EMA_WAIT,
        ST_REL_GO,
        ST_REL_WAIT,
        ST_FIN
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic prep;
        logic start_ema;
        logic take_ema;
        logic start_rel;
        logic take_rel;
        logic commit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_range;
        logic stable;
        logic ema_need;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/aood_div.sv
module aood_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [aood_pkg::DIV_DVD_W-1:0]   i_dvd,
    input  logic [aood_pkg::DIV_DVS_W-1:0]   i_dvs,
    output logic [aood_pkg::DIV_DVD_W-1:0]   o_quo,
    output logic                             o_done
);
    localparam int QW = aood_pkg::DIV_DVD_W;
    localparam int RW = aood_pkg::DIV_DVS_W;

    logic [QW-1:0] r_q, n_q;
    logic [RW-1:0] r_rem, n_rem;
    logic [RW-1:0] r_d;
    logic [aood_pkg::DIV_CNT_W-1:0] r_cnt;
    logic r_busy, r_done;

    // Two restoring steps per cycle
    always_comb begin
        logic [RW-1:0] rem;
        logic [QW-1:0] q;
        logic [RW:0]   t;
        rem = r_rem;
        q   = r_q;
        t   = '0;
        for (int k = 0; k < aood_pkg::DIV_BITS; k++) begin
            t = {rem, q[QW-1]};
            q = {q[QW-2:0], 1'b0};
            if (t >= {1'b0, r_d}) begin
                t = t - {1'b0, r_d};
                q[0] = 1'b1;
            end
            rem = t[RW-1:0];
        end
        n_q   = q;
        n_rem = rem;
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == aood_pkg::DIV_CNT_W'(aood_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Operand and partial result registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dvd;
            r_rem <= '0;
            r_d   <= i_dvs;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_quo  = r_q;
    assign o_done = r_done;

endmodule

>>> rtl/aood_dp.sv
module aood_dp #(
    parameter int BLOCKS = aood_pkg::BLOCKS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  aood_pkg::t_in                  i_in_data,
    output aood_pkg::t_out                 o_out_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  logic                           i_cfg_valid,
    input  logic [aood_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data,
    input  aood_pkg::t_cmd                 i_cmd,
    output aood_pkg::t_sts                 o_sts
);
    localparam int DEPTH = (BLOCKS < 8) ? BLOCKS : 8;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = aood_pkg::CUR_W;
    localparam int TW = aood_pkg::TIME_W;

    // Configuration registers
    logic [15:0] r_short, r_hard, r_hold, r_tau, r_jump, r_minb;
    logic [7:0]  r_num, r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short <= aood_pkg::RST_SHORT_LIMIT;
            r_hard  <= aood_pkg::RST_HARD_LIMIT;
            r_hold  <= aood_pkg::RST_HOLD_TIME;
            r_tau   <= aood_pkg::RST_EMA_TAU;
            r_num   <= aood_pkg::RST_FACTOR_NUM;
            r_den   <= aood_pkg::RST_FACTOR_DEN;
            r_jump  <= aood_pkg::RST_MIN_JUMP;
            r_minb  <= aood_pkg::RST_MIN_BASE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                aood_pkg::CFG_SHORT_LIMIT: r_short <= i_cfg_data;
                aood_pkg::CFG_HARD_LIMIT:  r_hard  <= i_cfg_data;
                aood_pkg::CFG_HOLD_TIME:   r_hold  <= i_cfg_data;
                aood_pkg::CFG_EMA_TAU:     r_tau   <= i_cfg_data;
                aood_pkg::CFG_FACTOR_NUM:  r_num   <= i_cfg_data[7:0];
                aood_pkg::CFG_FACTOR_DEN:  r_den   <= i_cfg_data[7:0];
                aood_pkg::CFG_MIN_JUMP:    r_jump  <= i_cfg_data;
                aood_pkg::CFG_MIN_BASE:    r_minb  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Latched input beat
    aood_pkg::t_in r_in;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) r_in <= i_in_data;
    end

    logic [IDX_W-1:0] idx;
    logic             in_range;
    assign idx      = IDX_W'(r_in.block_index);
    assign in_range = 32'(r_in.block_index) < BLOCKS;

    // Per-block state
    logic [CW-1:0] r_base_st [DEPTH];
    logic [TW-1:0] r_last_st [DEPTH];
    logic [TW-1:0] r_cand_st [DEPTH];

    // Working registers
    logic [CW-1:0] r_sbase, r_base, r_rel;
    logic [TW-1:0] r_dt, r_cstart;
    logic          r_last_set, r_neg;
    logic [aood_pkg::DIV_DVD_W-1:0] quo;

    // Prep: fetch state, first baseline choice, dt; later, apply the EMA step
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_sbase    <= r_base_st[idx];
            r_cstart   <= r_cand_st[idx];
            r_last_set <= (r_last_st[idx] != '0);
            r_dt       <= r_in.now_ms - r_last_st[idx];
            if (!r_in.occupied) begin
                r_base <= '0;
            end else if (r_base_st[idx] == '0) begin
                r_base <= r_in.current_ma;
            end else begin
                r_base <= r_base_st[idx];
            end
        end else if (i_cmd.take_ema) begin
            if (r_neg) r_base <= r_base - quo[CW-1:0];
            else       r_base <= r_base + quo[CW-1:0];
        end
    end

    logic ema_need;
    assign ema_need = r_in.occupied && (r_sbase != '0) && r_last_set &&
                      (r_dt != '0) && (r_dt < aood_pkg::DT_LIMIT_MS) && (r_tau != '0);

    // EMA operands: |sample - base| * dt over tau + dt
    logic [CW-1:0] mag;
    logic          neg;
    logic [aood_pkg::DIV_DVD_W-1:0] ema_dvd, rel_dvd, dvd;
    logic [aood_pkg::DIV_DVS_W-1:0] ema_dvs, rel_dvs, dvs;
    logic div_done;

    assign neg = r_in.current_ma < r_sbase;
    assign mag = neg ? (r_sbase - r_in.current_ma) : (r_in.current_ma - r_sbase);
    assign ema_dvd = aood_pkg::DIV_DVD_W'(mag) *
                     aood_pkg::DIV_DVD_W'(r_dt[aood_pkg::DT_W-1:0]);
    assign ema_dvs = aood_pkg::DIV_DVS_W'(r_tau) +
                     aood_pkg::DIV_DVS_W'(r_dt[aood_pkg::DT_W-1:0]);

    // Relative threshold operands
    assign rel_dvd = aood_pkg::DIV_DVD_W'(r_base) * aood_pkg::DIV_DVD_W'(r_num);
    assign rel_dvs = (r_den == '0) ? aood_pkg::DIV_DVS_W'(1) : aood_pkg::DIV_DVS_W'(r_den);

    assign dvd = i_cmd.start_rel ? rel_dvd : ema_dvd;
    assign dvs = i_cmd.start_rel ? rel_dvs : ema_dvs;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_ema) r_neg <= neg;
        if (i_cmd.take_rel)  r_rel <= quo[CW-1:0];
    end

    aood_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start_ema | i_cmd.start_rel),
        .i_dvd   (dvd),
        .i_dvs   (dvs),
        .o_quo   (quo),
        .o_done  (div_done)
    );

    // Threshold and candidate decision
    logic [CW-1:0] abs_thr, thr;
    logic          hard, adaptive, cand, trip;
    logic [TW-1:0] start_t;
    assign abs_thr  = r_base + r_jump;
    assign thr      = (r_rel > abs_thr) ? r_rel : abs_thr;
    assign hard     = r_in.current_ma >= r_hard;
    assign adaptive = (r_base >= r_minb) && (r_in.current_ma >= thr);
    assign cand     = r_in.occupied && (r_in.current_ma < r_short) && (hard || adaptive);
    assign start_t  = (r_cstart == '0) ? r_in.now_ms : r_cstart;
    assign trip     = cand && ((r_in.now_ms - start_t) >= TW'(r_hold));

    // State write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < DEPTH; b++) begin
                r_base_st[b] <= '0;
                r_last_st[b] <= '0;
                r_cand_st[b] <= '0;
            end
        end else if (i_cmd.commit && in_range) begin
            if (!r_in.power_stable) begin
                r_base_st[idx] <= '0;
                r_last_st[idx] <= '0;
                r_cand_st[idx] <= '0;
            end else begin
                r_base_st[idx] <= r_base;
                r_last_st[idx] <= r_in.occupied ? r_in.now_ms : '0;
                r_cand_st[idx] <= cand ? start_t : '0;
            end
        end
    end

    // Output register
    logic          r_out_valid;
    aood_pkg::t_out r_out;
    logic          live;
    assign live = in_range && r_in.power_stable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.block_out    <= r_in.block_index;
            r_out.trip         <= live && trip;
            r_out.hard_cause   <= live && trip && hard;
            r_out.baseline_out <= live ? r_base : '0;
        end
    end

    assign o_out_data  = r_out;
    assign o_out_valid = r_out_valid;

    assign o_sts.in_range = in_range;
    assign o_sts.stable   = r_in.power_stable;
    assign o_sts.ema_need = ema_need;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

endmodule

>>> rtl/aood_ctrl.sv
module aood_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  aood_pkg::t_sts i_sts,
    output aood_pkg::t_cmd o_cmd
);
    aood_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= aood_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            aood_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = aood_pkg::ST_PREP;
                end
            end
            aood_pkg::ST_PREP: begin
                o_cmd.prep = 1'b1;
                if (!i_sts.in_range || !i_sts.stable) n_state = aood_pkg::ST_FIN;
                else                                  n_state = aood_pkg::ST_MUL;
            end
            aood_pkg::ST_MUL: begin
                if (i_sts.ema_need) begin
                    o_cmd.start_ema = 1'b1;
                    n_state = aood_pkg::ST_EMA_WAIT;
                end else begin
                    n_state = aood_pkg::ST_REL_GO;
                end
            end
            aood_pkg::ST_EMA_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.take_ema = 1'b1;
                    n_state = aood_pkg::ST_REL_GO;
                end
            end
            aood_pkg::ST_REL_GO: begin
                o_cmd.start_rel = 1'b1;
                n_state = aood_pkg::ST_REL_WAIT;
            end
            aood_pkg::ST_REL_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.take_rel = 1'b1;
                    n_state = aood_pkg::ST_FIN;
                end
            end
            aood_pkg::ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = aood_pkg::ST_IDLE;
                end
            end
            default: n_state = aood_pkg::ST_IDLE;
        endcase
    end

endmodule

>>> rtl/adaptive_overcurrent_occupancy_detector.sv
// Channel  Direction  Signals                                   Payload
// in       input      i_in_valid / o_in_ready                   aood_pkg::t_in
// out      output     o_out_valid / i_out_ready                 aood_pkg::t_out
// cfg      input      i_cfg_valid / o_cfg_ready, i_cfg_index    i_cfg_data (16 bits)
//
// One beat in flight at a time. The shared 2-bit-per-cycle divider serves
// the EMA step and the relative threshold: a beat whose baseline is averaged
// runs it twice, one that is not runs it once, and a beat for an unstable or
// out-of-range block skips it. Reset is synchronous and clears all block
// state; no clearing pass. A stalled output beat holds in the output register
// while the next input beat is taken and worked on.
module adaptive_overcurrent_occupancy_detector #(
    parameter int BLOCKS = aood_pkg::BLOCKS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  aood_pkg::t_in                  i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output aood_pkg::t_out                 o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [aood_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);
    aood_pkg::t_cmd cmd;
    aood_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    aood_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    aood_dp #(
        .BLOCKS (BLOCKS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

>>> rtl/aood_checker.sv
module aood_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input aood_pkg::t_out o_out_data
);
    // Output beat stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    // Reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // One beat at a time: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while a beat is in work");

    // Hard cause only comes with a trip
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.trip || !o_out_data.hard_cause))
        else $error("hard cause without trip");

endmodule

bind adaptive_overcurrent_occupancy_detector aood_checker u_aood_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

>>> verif/tb_adaptive_overcurrent_occupancy_detector.sv
module tb_adaptive_overcurrent_occupancy_detector;

    localparam int NBLK = 8;
    localparam logic [31:0] DT_WINDOW = 32'd5000;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_in_valid = 1'b0;
    logic           o_in_ready;
    aood_pkg::t_in  i_in_data = '0;
    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    aood_pkg::t_out o_out_data;
    logic           i_cfg_valid = 1'b0;
    logic           o_cfg_ready;
    logic [2:0]     i_cfg_index = '0;
    logic [15:0]    i_cfg_data = '0;

    adaptive_overcurrent_occupancy_detector dut (.*);

    always #10 i_clk = ~i_clk;

    // Predictor copy of the registers and per-block state
    logic [15:0] r_short, r_hard, r_hold, r_tau, r_jump, r_bmin;
    logic [7:0]  r_num, r_den;
    logic [15:0] base_mem [NBLK];
    logic [31:0] upd_mem  [NBLK];
    logic [31:0] cand_mem [NBLK];

    aood_pkg::t_in  sample_q [$];
    aood_pkg::t_out verdict_q [$];
    int   n_err = 0;
    int   n_seen = 0;
    bit   quiet = 1'b0;   // stretch with no idling

    // Work out one sample's verdict and update predictor state
    function automatic aood_pkg::t_out detect(aood_pkg::t_in s);
        aood_pkg::t_out r;
        logic [2:0]  b;
        logic [31:0] dt, den, rel, absthr, thr;
        longint      diff, delta, nxt;
        logic        hard, adapt, cand;
        r = '0;
        b = s.block_index;
        r.block_out = b;
        if (!s.power_stable) begin
            base_mem[b] = '0; upd_mem[b] = '0; cand_mem[b] = '0;
            return r;
        end
        if (s.occupied) begin
            dt = (upd_mem[b] == 0) ? 32'd0 : s.now_ms - upd_mem[b];
            upd_mem[b] = s.now_ms;
            if (base_mem[b] == 0)
                base_mem[b] = s.current_ma;
            else if (dt > 0 && dt < DT_WINDOW && r_tau != 0) begin
                diff  = longint'(s.current_ma) - longint'(base_mem[b]);
                delta = (diff * longint'(dt)) / (longint'(r_tau) + longint'(dt));
                nxt   = longint'(base_mem[b]) + delta;
                if (nxt < 0) nxt = 0;
                if (nxt > 65535) nxt = 65535;
                base_mem[b] = nxt[15:0];
            end
        end else begin
            base_mem[b] = '0; upd_mem[b] = '0;
        end
        den    = (r_den == 0) ? 32'd1 : {24'd0, r_den};
        rel    = (({16'd0, base_mem[b]} * r_num) / den) & 32'hFFFF;
        absthr = ({16'd0, base_mem[b]} + r_jump) & 32'hFFFF;
        thr    = (rel > absthr) ? rel : absthr;
        hard   = s.current_ma >= r_hard;
        adapt  = (base_mem[b] >= r_bmin) && ({16'd0, s.current_ma} >= thr);
        cand   = s.occupied && (s.current_ma < r_short) && (hard || adapt);
        if (cand) begin
            if (cand_mem[b] == 0) cand_mem[b] = s.now_ms;
            if (s.now_ms - cand_mem[b] >= r_hold) begin
                r.trip = 1'b1;
                r.hard_cause = hard;
            end
        end else
            cand_mem[b] = '0;
        r.baseline_out = base_mem[b];
        return r;
    endfunction

    // Driver: sample beats from the pending queue
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            verdict_q.push_back(detect(i_in_data));
            void'(sample_q.pop_front());
        end
        if (!i_in_valid || o_in_ready) begin
            if (i_rst_n && (sample_q.size() != 0)
                && (quiet || $urandom_range(99) >= 11)) begin
                i_in_valid <= 1'b1;
                i_in_data  <= sample_q[0];
            end else
                i_in_valid <= 1'b0;
        end
    end

    // Monitor: compare verdict beats
    always @(posedge i_clk) begin
        i_out_ready <= quiet || ($urandom_range(99) >= 11);
        if (o_out_valid && i_out_ready) begin
            n_seen++;
            if (verdict_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected beat %p", o_out_data);
            end else begin
                if (o_out_data !== verdict_q[0]) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch exp %p got %p", verdict_q[0], o_out_data);
                end
                void'(verdict_q.pop_front());
            end
        end
    end

    task automatic cfg_write(aood_pkg::t_cfg_idx idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            aood_pkg::CFG_SHORT_LIMIT: r_short = val;
            aood_pkg::CFG_HARD_LIMIT:  r_hard  = val;
            aood_pkg::CFG_HOLD_TIME:   r_hold  = val;
            aood_pkg::CFG_EMA_TAU:     r_tau   = val;
            aood_pkg::CFG_FACTOR_NUM:  r_num   = val[7:0];
            aood_pkg::CFG_FACTOR_DEN:  r_den   = val[7:0];
            aood_pkg::CFG_MIN_JUMP:    r_jump  = val;
            aood_pkg::CFG_MIN_BASE:    r_bmin  = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        // sample_q empties only once the last beat is taken
        while (sample_q.size() != 0 || i_in_valid || verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic add(logic [2:0] b, logic [15:0] c, logic occ, logic st, logic [31:0] t);
        aood_pkg::t_in s;
        s.block_index = b; s.current_ma = c; s.occupied = occ;
        s.power_stable = st; s.now_ms = t;
        sample_q.push_back(s);
    endtask

    // Mostly well-formed per-block streams with advancing time
    task automatic random_phase(int n, logic [31:0] t0);
        logic [31:0] clk_ms [NBLK];
        logic [2:0]  b;
        logic [15:0] c;
        for (int i = 0; i < NBLK; i++) clk_ms[i] = t0 + $urandom_range(1000);
        for (int i = 0; i < n; i++) begin
            b = 3'($urandom_range(7));
            case ($urandom_range(9))
                0: clk_ms[b] = $urandom;
                1, 2: clk_ms[b] += $urandom_range(9000);
                default: clk_ms[b] += $urandom_range(400);
            endcase
            case ($urandom_range(5))
                0: c = 16'($urandom);
                1: c = 16'($urandom_range(100));
                2: c = 16'hFFFF - 16'($urandom_range(3));
                default: c = 16'($urandom_range(3000));
            endcase
            add(b, c, $urandom_range(9) != 0, $urandom_range(19) != 0, clk_ms[b]);
        end
    endtask

    initial begin
        r_short = aood_pkg::RST_SHORT_LIMIT; r_hard = aood_pkg::RST_HARD_LIMIT;
        r_hold = aood_pkg::RST_HOLD_TIME; r_tau = aood_pkg::RST_EMA_TAU;
        r_num = aood_pkg::RST_FACTOR_NUM; r_den = aood_pkg::RST_FACTOR_DEN;
        r_jump = aood_pkg::RST_MIN_JUMP; r_bmin = aood_pkg::RST_MIN_BASE;
        for (int i = 0; i < NBLK; i++) begin
            base_mem[i] = '0; upd_mem[i] = '0; cand_mem[i] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: baseline set, EMA, hard and adaptive trips, persistence
        add(3'd0, 16'd100, 1, 1, 32'd1000);
        add(3'd0, 16'd200, 1, 1, 32'd1100);
        add(3'd0, 16'd1600, 1, 1, 32'd1200);
        add(3'd0, 16'd1600, 1, 1, 32'd1800);
        add(3'd0, 16'd1600, 1, 1, 32'd1900);
        add(3'd0, 16'd100, 0, 1, 32'd2000);
        add(3'd1, 16'd400, 1, 1, 32'd10);
        add(3'd1, 16'd900, 1, 1, 32'd20);
        add(3'd1, 16'd900, 1, 1, 32'd700);
        add(3'd1, 16'd2600, 1, 1, 32'd800);
        add(3'd1, 16'd0, 1, 1, 32'd9000);
        add(3'd2, 16'hFFFF, 1, 1, 32'hFFFF_FFFF);
        add(3'd2, 16'hFFFF, 1, 1, 32'd3);
        add(3'd2, 16'd5, 1, 0, 32'd50);
        add(3'd7, 16'd1500, 1, 1, 32'd0);
        add(3'd7, 16'd2499, 1, 1, 32'd600);
        add(3'd7, 16'd10, 1, 1, 32'd4999);
        quiet = 1'b1;
        drain();
        quiet = 1'b0;

        random_phase(200, 32'd100);
        drain();

        // Extremes: zero tau, zero denominator, wide limits
        cfg_write(aood_pkg::CFG_SHORT_LIMIT, 16'hFFFF);
        cfg_write(aood_pkg::CFG_HARD_LIMIT, 16'hFFFF);
        cfg_write(aood_pkg::CFG_HOLD_TIME, 16'd0);
        cfg_write(aood_pkg::CFG_EMA_TAU, 16'd0);
        cfg_write(aood_pkg::CFG_FACTOR_NUM, 16'd255);
        cfg_write(aood_pkg::CFG_FACTOR_DEN, 16'd0);
        cfg_write(aood_pkg::CFG_MIN_JUMP, 16'hFFFF);
        cfg_write(aood_pkg::CFG_MIN_BASE, 16'd0);
        random_phase(170, 32'hFFFF_F000);
        quiet = 1'b1;
        drain();
        quiet = 1'b0;

        cfg_write(aood_pkg::CFG_SHORT_LIMIT, 16'd0);
        cfg_write(aood_pkg::CFG_HARD_LIMIT, 16'd0);
        cfg_write(aood_pkg::CFG_HOLD_TIME, 16'hFFFF);
        cfg_write(aood_pkg::CFG_EMA_TAU, 16'hFFFF);
        cfg_write(aood_pkg::CFG_FACTOR_NUM, 16'd0);
        cfg_write(aood_pkg::CFG_FACTOR_DEN, 16'd255);
        cfg_write(aood_pkg::CFG_MIN_JUMP, 16'd0);
        cfg_write(aood_pkg::CFG_MIN_BASE, 16'hFFFF);
        random_phase(130, 32'd5000);
        drain();

        cfg_write(aood_pkg::CFG_SHORT_LIMIT, 16'd3000);
        cfg_write(aood_pkg::CFG_HARD_LIMIT, 16'd1200);
        cfg_write(aood_pkg::CFG_HOLD_TIME, 16'd100);
        cfg_write(aood_pkg::CFG_EMA_TAU, 16'd1);
        cfg_write(aood_pkg::CFG_FACTOR_NUM, 16'd2);
        cfg_write(aood_pkg::CFG_FACTOR_DEN, 16'd1);
        cfg_write(aood_pkg::CFG_MIN_JUMP, 16'd50);
        cfg_write(aood_pkg::CFG_MIN_BASE, 16'd10);
        random_phase(200, 32'h8000_0000);
        drain();

        if (n_err == 0 && verdict_q.size() == 0)
            $display("tb_adaptive_overcurrent_occupancy_detector: PASS");
        else
            $display("tb_adaptive_overcurrent_occupancy_detector: FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #20000000;
        $display("tb_adaptive_overcurrent_occupancy_detector: FAIL");
        $finish;
    end

endmodule
